@@ rtl/pfb_pkg.sv @@
// ----------------------------------------------------------------------------
// pfb_pkg - shared constants, codes and helpers for the page framebuffer
// Screen geometry, opcode values, controller states and address helpers.
// ----------------------------------------------------------------------------
package pfb_pkg;

   // Screen geometry
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int GLYPH_COUNT   = 95;

   localparam int GLYPH_COLS    = 5;
   localparam int GLYPH_ROWS    = 7;
   localparam int CHAR_ADVANCE  = 6;

   localparam int PAGE_COUNT     = (SCREEN_HEIGHT + 7) / 8;
   localparam int FRAME_BYTES    = SCREEN_WIDTH * PAGE_COUNT;
   localparam int FRAME_AW       = $clog2(FRAME_BYTES);
   localparam int FONT_DEPTH     = GLYPH_COUNT * GLYPH_COLS;
   localparam int FONT_AW        = $clog2(FONT_DEPTH);
   localparam int COL_W          = $clog2(SCREEN_WIDTH);
   localparam int LAST_PAGE_ROWS = SCREEN_HEIGHT - 8 * (PAGE_COUNT - 1);
   localparam logic [7:0] LAST_PAGE_MASK = 8'((16'd1 << LAST_PAGE_ROWS) - 16'd1);

   // Character codes
   localparam logic [7:0] FIRST_CODE    = 8'h20;
   localparam logic [7:0] LAST_CODE     = 8'h7E;
   localparam logic [7:0] FALLBACK_CODE = 8'h3F;

   // Opcodes
   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_PLOT   = 3'd1;
   localparam logic [2:0] OP_HLINE  = 3'd2;
   localparam logic [2:0] OP_CURSOR = 3'd3;
   localparam logic [2:0] OP_CHAR   = 3'd4;
   localparam logic [2:0] OP_FONT   = 3'd5;
   localparam logic [2:0] OP_READ   = 3'd6;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PLOT,
      ST_LINE,
      ST_READ,
      ST_GLYPH_RD0,
      ST_GLYPH_WR0,
      ST_GLYPH_WR1,
      ST_FINISH
   } state_type;

   // Byte address of a page/column pair
   function automatic logic [FRAME_AW-1:0] frame_addr(input logic [4:0] page,
                                                       input logic [9:0] col);
      frame_addr = FRAME_AW'(int'(page) * SCREEN_WIDTH + int'(col));
   endfunction

   // Rows of a page that lie on the screen
   function automatic logic [7:0] page_row_mask(input logic [4:0] page);
      logic [7:0] mask;
      if (int'(page) < PAGE_COUNT - 1) begin
         mask = 8'hFF;
      end else if (int'(page) == PAGE_COUNT - 1) begin
         mask = LAST_PAGE_MASK;
      end else begin
         mask = 8'h00;
      end
      page_row_mask = mask;
   endfunction

   function automatic logic code_ok(input logic [7:0] code);
      code_ok = (code >= FIRST_CODE) && (code <= LAST_CODE);
   endfunction

   // First font entry of a glyph; bad codes map to the fallback glyph
   function automatic logic [FONT_AW-1:0] glyph_base(input logic [7:0] code);
      logic [7:0] c;
      c = code_ok(code) ? code : FALLBACK_CODE;
      glyph_base = FONT_AW'(int'(c - FIRST_CODE) * GLYPH_COLS);
   endfunction

endpackage

@@ rtl/page_framebuffer_text_renderer.sv @@
// ----------------------------------------------------------------------------
// page_framebuffer_text_renderer - page-organized framebuffer with 5x7 text
// Frame bytes and font columns live in two synchronous RAMs; a sequencer
// walks each operation as byte read-modify-write passes.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  req_tdata (48b): one command word
//   rsp_     out  rsp_tvalid/rsp_tready  rsp_tdata (24b): one result word
//
// An hline walks one column per cycle through the frame RAM; put char walks
// each glyph column as a frame read, a lower-page write and an upper-page
// write. After reset a clearing pass over all FRAME_BYTES (1024) bytes
// zeroes the frame RAM with req_tready low. A new word is taken while the
// last result still waits in the output register; a stalled rsp_ side
// holds the next result.
// ----------------------------------------------------------------------------
module page_framebuffer_text_renderer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0] pos_x[10:3] pos_y[17:11] pixel_on[18] char_code[26:19]
   // font_column[29:27] font_bits[36:30] read_page[39:37] read_column[46:40]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0] cursor_now[16:8] text_stopped[17]
   output logic [23:0] rsp_tdata
);

   localparam int FAW = pfb_pkg::FRAME_AW;
   localparam int NAW = pfb_pkg::FONT_AW;
   localparam int CW  = pfb_pkg::COL_W;

   // Command fields
   logic [2:0] req_opcode;
   logic [7:0] req_pos_x;
   logic [6:0] req_pos_y;
   logic       req_pixel_on;
   logic [7:0] req_char_code;
   logic [2:0] req_font_column;
   logic [6:0] req_font_bits;
   logic [2:0] req_read_page;
   logic [6:0] req_read_column;

   assign req_opcode      = req_tdata[2:0];
   assign req_pos_x       = req_tdata[10:3];
   assign req_pos_y       = req_tdata[17:11];
   assign req_pixel_on    = req_tdata[18];
   assign req_char_code   = req_tdata[26:19];
   assign req_font_column = req_tdata[29:27];
   assign req_font_bits   = req_tdata[36:30];
   assign req_read_page   = req_tdata[39:37];
   assign req_read_column = req_tdata[46:40];

   pfb_pkg::state_type state_ff, state_in;

   // Control registers
   logic           rsp_valid_ff, rsp_valid_in;
   logic [8:0]     cursor_col_ff, cursor_col_in;
   logic [6:0]     cursor_row_ff, cursor_row_in;
   logic           line_full_ff, line_full_in;
   logic [FAW-1:0] clear_cnt_ff, clear_cnt_in;
   logic           clear_op_ff, clear_op_in;

   // Work registers
   logic [CW:0]    line_col_ff, line_col_in;
   logic [4:0]     line_page_ff, line_page_in;
   logic [FAW-1:0] addr_a_ff, addr_a_in;
   logic [FAW-1:0] addr_b_ff, addr_b_in;
   logic [7:0]     mask_a_ff, mask_a_in;
   logic [7:0]     mask_b_ff, mask_b_in;
   logic           pix_set_ff, pix_set_in;
   logic           pix_en_ff, pix_en_in;
   logic           read_ok_ff, read_ok_in;
   logic [7:0]     read_byte_ff, read_byte_in;
   logic [8:0]     glyph_x_ff, glyph_x_in;
   logic [6:0]     glyph_y_ff, glyph_y_in;
   logic [NAW-1:0] glyph_base_ff, glyph_base_in;
   logic [2:0]     glyph_col_ff, glyph_col_in;

   // Result registers
   logic [7:0]     rsp_read_ff, rsp_read_in;
   logic [8:0]     rsp_cursor_ff, rsp_cursor_in;
   logic           rsp_stop_ff, rsp_stop_in;

   // RAM ports
   logic           frame_we;
   logic [FAW-1:0] frame_wa, frame_ra;
   logic [7:0]     frame_wd, frame_rd;
   logic           font_we;
   logic [NAW-1:0] font_wa, font_ra;
   logic [pfb_pkg::GLYPH_ROWS-1:0] font_wd, font_rd;

   logic accept;
   logic rsp_free;
   logic clear_done;
   logic line_done;
   logic line_row_ok;
   logic glyph_last;
   logic [4:0] plot_page;

   // Glyph column geometry
   logic [9:0]     g_x;
   logic           g_col_ok;
   logic [14:0]    g_shift;
   logic [4:0]     g_p0, g_p1;
   logic [7:0]     g_m0, g_m1;
   logic [FAW-1:0] g_a0, g_a1;

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = (state_ff == pfb_pkg::ST_IDLE);
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign clear_done  = (clear_cnt_ff == FAW'(pfb_pkg::FRAME_BYTES - 1));
   assign line_done   = (line_col_ff == (CW+1)'(pfb_pkg::SCREEN_WIDTH));
   assign line_row_ok = int'(req_pos_y) < pfb_pkg::SCREEN_HEIGHT;
   assign glyph_last  = (glyph_col_ff == 3'(pfb_pkg::GLYPH_COLS - 1));
   assign plot_page   = {1'b0, req_pos_y[6:3]};

   assign g_x      = {1'b0, glyph_x_ff} + {7'd0, glyph_col_ff};
   assign g_col_ok = int'(g_x) < pfb_pkg::SCREEN_WIDTH;
   assign g_shift  = 15'(font_rd) << glyph_y_ff[2:0];
   assign g_p0     = {1'b0, glyph_y_ff[6:3]};
   assign g_p1     = g_p0 + 5'd1;
   assign g_m0     = g_col_ok ? (g_shift[7:0] & pfb_pkg::page_row_mask(g_p0)) : 8'd0;
   assign g_m1     = g_col_ok ? ({1'b0, g_shift[14:8]} & pfb_pkg::page_row_mask(g_p1))
                              : 8'd0;
   assign g_a0     = pfb_pkg::frame_addr(g_p0, g_x);
   assign g_a1     = pfb_pkg::frame_addr(g_p1, g_x);

   pfb_ram #(
      .DEPTH (pfb_pkg::FRAME_BYTES),
      .ADDR_W(FAW),
      .DATA_W(8)
   ) u_frame_ram (
      .clock  (clock),
      .wr_en  (frame_we),
      .wr_addr(frame_wa),
      .wr_data(frame_wd),
      .rd_addr(frame_ra),
      .rd_data(frame_rd)
   );

   pfb_ram #(
      .DEPTH (pfb_pkg::FONT_DEPTH),
      .ADDR_W(NAW),
      .DATA_W(pfb_pkg::GLYPH_ROWS)
   ) u_font_ram (
      .clock  (clock),
      .wr_en  (font_we),
      .wr_addr(font_wa),
      .wr_data(font_wd),
      .rd_addr(font_ra),
      .rd_data(font_rd)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfb_pkg::ST_CLEAR: begin
            if (clear_done) begin
               state_in = clear_op_ff ? pfb_pkg::ST_FINISH : pfb_pkg::ST_IDLE;
            end
         end
         pfb_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  pfb_pkg::OP_CLEAR: state_in = pfb_pkg::ST_CLEAR;
                  pfb_pkg::OP_PLOT:  state_in = pfb_pkg::ST_PLOT;
                  pfb_pkg::OP_HLINE: begin
                     state_in = line_row_ok ? pfb_pkg::ST_LINE : pfb_pkg::ST_FINISH;
                  end
                  pfb_pkg::OP_CHAR: begin
                     state_in = line_full_ff ? pfb_pkg::ST_FINISH : pfb_pkg::ST_GLYPH_RD0;
                  end
                  pfb_pkg::OP_READ:  state_in = pfb_pkg::ST_READ;
                  default:           state_in = pfb_pkg::ST_FINISH;
               endcase
            end
         end
         pfb_pkg::ST_PLOT:      state_in = pfb_pkg::ST_FINISH;
         pfb_pkg::ST_LINE: begin
            if (line_done) begin
               state_in = pfb_pkg::ST_FINISH;
            end
         end
         pfb_pkg::ST_READ:      state_in = pfb_pkg::ST_FINISH;
         pfb_pkg::ST_GLYPH_RD0: state_in = pfb_pkg::ST_GLYPH_WR0;
         pfb_pkg::ST_GLYPH_WR0: state_in = pfb_pkg::ST_GLYPH_WR1;
         pfb_pkg::ST_GLYPH_WR1: begin
            state_in = glyph_last ? pfb_pkg::ST_FINISH : pfb_pkg::ST_GLYPH_RD0;
         end
         pfb_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = pfb_pkg::ST_IDLE;
            end
         end
         default: state_in = pfb_pkg::ST_IDLE;
      endcase
   end

   // Outputs: RAM controls and register next values
   always_comb begin
      frame_we = 1'b0;
      frame_wa = addr_a_ff;
      frame_wd = 8'd0;
      frame_ra = addr_a_ff;
      font_we  = 1'b0;
      font_wa  = pfb_pkg::glyph_base(req_char_code) + NAW'(req_font_column);
      font_wd  = req_font_bits;
      font_ra  = glyph_base_ff;

      rsp_valid_in  = rsp_valid_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      line_full_in  = line_full_ff;
      clear_cnt_in  = clear_cnt_ff;
      clear_op_in   = clear_op_ff;
      line_col_in   = line_col_ff;
      line_page_in  = line_page_ff;
      addr_a_in     = addr_a_ff;
      addr_b_in     = addr_b_ff;
      mask_a_in     = mask_a_ff;
      mask_b_in     = mask_b_ff;
      pix_set_in    = pix_set_ff;
      pix_en_in     = pix_en_ff;
      read_ok_in    = read_ok_ff;
      read_byte_in  = read_byte_ff;
      glyph_x_in    = glyph_x_ff;
      glyph_y_in    = glyph_y_ff;
      glyph_base_in = glyph_base_ff;
      glyph_col_in  = glyph_col_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_stop_in   = rsp_stop_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pfb_pkg::ST_CLEAR: begin
            frame_we     = 1'b1;
            frame_wa     = clear_cnt_ff;
            clear_cnt_in = clear_done ? '0 : clear_cnt_ff + 1'b1;
         end
         pfb_pkg::ST_IDLE: begin
            frame_ra = (req_opcode == pfb_pkg::OP_READ)
                     ? pfb_pkg::frame_addr({2'd0, req_read_page}, {3'd0, req_read_column})
                     : pfb_pkg::frame_addr(plot_page, {2'd0, req_pos_x});
            font_ra  = pfb_pkg::glyph_base(req_char_code);
            if (accept) begin
               read_byte_in = 8'd0;
               clear_op_in  = 1'b0;
               case (req_opcode)
                  pfb_pkg::OP_CLEAR: clear_op_in = 1'b1;
                  pfb_pkg::OP_PLOT: begin
                     addr_a_in  = pfb_pkg::frame_addr(plot_page, {2'd0, req_pos_x});
                     mask_a_in  = 8'd1 << req_pos_y[2:0];
                     pix_set_in = req_pixel_on;
                     pix_en_in  = (int'(req_pos_x) < pfb_pkg::SCREEN_WIDTH) && line_row_ok;
                  end
                  pfb_pkg::OP_HLINE: begin
                     mask_a_in    = 8'd1 << req_pos_y[2:0];
                     line_page_in = plot_page;
                     line_col_in  = '0;
                  end
                  pfb_pkg::OP_CURSOR: begin
                     cursor_col_in = {1'b0, req_pos_x};
                     cursor_row_in = req_pos_y;
                     line_full_in  = 1'b0;
                  end
                  pfb_pkg::OP_CHAR: begin
                     if (!line_full_ff) begin
                        glyph_x_in    = cursor_col_ff;
                        glyph_y_in    = cursor_row_ff;
                        glyph_base_in = pfb_pkg::glyph_base(req_char_code);
                        glyph_col_in  = 3'd0;
                        cursor_col_in = cursor_col_ff + 9'(pfb_pkg::CHAR_ADVANCE);
                        line_full_in  = int'(cursor_col_in)
                                      > pfb_pkg::SCREEN_WIDTH - pfb_pkg::CHAR_ADVANCE;
                     end
                  end
                  pfb_pkg::OP_FONT: begin
                     font_we = pfb_pkg::code_ok(req_char_code)
                             && (int'(req_font_column) < pfb_pkg::GLYPH_COLS);
                  end
                  pfb_pkg::OP_READ: begin
                     read_ok_in = (int'(req_read_page) < pfb_pkg::PAGE_COUNT)
                                && (int'(req_read_column) < pfb_pkg::SCREEN_WIDTH);
                  end
                  default: begin
                  end
               endcase
            end
         end
         pfb_pkg::ST_PLOT: begin
            frame_we = pix_en_ff;
            frame_wa = addr_a_ff;
            frame_wd = pix_set_ff ? (frame_rd | mask_a_ff) : (frame_rd & ~mask_a_ff);
         end
         pfb_pkg::ST_LINE: begin
            // read column n while writing back column n-1
            frame_ra    = pfb_pkg::frame_addr(line_page_ff, 10'(line_col_ff));
            frame_we    = (line_col_ff != '0);
            frame_wa    = pfb_pkg::frame_addr(line_page_ff, 10'(line_col_ff - 1'b1));
            frame_wd    = frame_rd | mask_a_ff;
            line_col_in = line_col_ff + 1'b1;
         end
         pfb_pkg::ST_READ: begin
            read_byte_in = read_ok_ff ? frame_rd : 8'd0;
         end
         pfb_pkg::ST_GLYPH_RD0: begin
            frame_ra  = g_a0;
            addr_a_in = g_a0;
            addr_b_in = g_a1;
            mask_a_in = g_m0;
            mask_b_in = g_m1;
         end
         pfb_pkg::ST_GLYPH_WR0: begin
            frame_we = (mask_a_ff != 8'd0);
            frame_wa = addr_a_ff;
            frame_wd = frame_rd | mask_a_ff;
            frame_ra = addr_b_ff;
         end
         pfb_pkg::ST_GLYPH_WR1: begin
            frame_we = (mask_b_ff != 8'd0);
            frame_wa = addr_b_ff;
            frame_wd = frame_rd | mask_b_ff;
            font_ra  = glyph_base_ff + NAW'(glyph_col_ff + 3'd1);
            if (!glyph_last) begin
               glyph_col_in = glyph_col_ff + 3'd1;
            end
         end
         pfb_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_read_in   = read_byte_ff;
               rsp_cursor_in = cursor_col_ff;
               rsp_stop_in   = line_full_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pfb_pkg::ST_CLEAR;
         rsp_valid_ff  <= 1'b0;
         cursor_col_ff <= 9'd0;
         cursor_row_ff <= 7'd0;
         line_full_ff  <= 1'b0;
         clear_cnt_ff  <= '0;
         clear_op_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         line_full_ff  <= line_full_in;
         clear_cnt_ff  <= clear_cnt_in;
         clear_op_ff   <= clear_op_in;
      end
   end

   always_ff @(posedge clock) begin
      line_col_ff   <= line_col_in;
      line_page_ff  <= line_page_in;
      addr_a_ff     <= addr_a_in;
      addr_b_ff     <= addr_b_in;
      mask_a_ff     <= mask_a_in;
      mask_b_ff     <= mask_b_in;
      pix_set_ff    <= pix_set_in;
      pix_en_ff     <= pix_en_in;
      read_ok_ff    <= read_ok_in;
      read_byte_ff  <= read_byte_in;
      glyph_x_ff    <= glyph_x_in;
      glyph_y_ff    <= glyph_y_in;
      glyph_base_ff <= glyph_base_in;
      glyph_col_ff  <= glyph_col_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_stop_ff   <= rsp_stop_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_stop_ff, rsp_cursor_ff, rsp_read_ff};

endmodule

@@ rtl/pfb_ram.sv @@
// ----------------------------------------------------------------------------
// pfb_ram - simple dual-port synchronous RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module pfb_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ test/tb_page_framebuffer_text_renderer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_framebuffer_text_renderer - self-checking bench for the text renderer
// Uploads a random font, runs a directed list of edge cases, then random
// drawing, text runs and byte reads under varying valid/ready pressure.
// A scoreboard mirrors the frame bytes, font and cursor, and checks each
// response word against its prediction.
// ----------------------------------------------------------------------------
module tb_page_framebuffer_text_renderer;

   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int QUIET_LIMIT = 8000;
   localparam int TAIL_CYCLES = 64;

   // packed as on req_tdata, lowest field last
   typedef struct packed {
      logic       pad;
      logic [6:0] read_column;
      logic [2:0] read_page;
      logic [6:0] font_bits;
      logic [2:0] font_column;
      logic [7:0] char_code;
      logic       pixel_on;
      logic [6:0] pos_y;
      logic [7:0] pos_x;
      logic [2:0] opcode;
   } cmd_type;

   typedef struct packed {
      logic [5:0] pad;
      logic       text_stopped;
      logic [8:0] cursor_now;
      logic [7:0] read_data;
   } rsp_type;

   class frame_scoreboard;
      logic [7:0] frame_bytes [pfb_pkg::FRAME_BYTES];
      logic [6:0] font_cols [pfb_pkg::FONT_DEPTH];
      logic [8:0] cursor_col;
      logic [6:0] cursor_row;
      logic       line_full;
      rsp_type    expected_results [$];
      int         errors;

      function new();
         foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
         foreach (font_cols[i]) font_cols[i] = 7'h00;
         cursor_col = '0;
         cursor_row = '0;
         line_full  = 1'b0;
         errors     = 0;
      endfunction

      function void set_pixel(int x, int y, bit on);
         int idx;
         if (x >= pfb_pkg::SCREEN_WIDTH || y >= pfb_pkg::SCREEN_HEIGHT) return;
         idx = (y / 8) * pfb_pkg::SCREEN_WIDTH + x;
         frame_bytes[idx][y % 8] = on;
      endfunction

      function void draw_glyph(int x, int y, logic [7:0] code);
         int base;
         logic [6:0] bits;
         if (code < pfb_pkg::FIRST_CODE || code > pfb_pkg::LAST_CODE) begin
            code = pfb_pkg::FALLBACK_CODE;
         end
         base = (int'(code) - int'(pfb_pkg::FIRST_CODE)) * pfb_pkg::GLYPH_COLS;
         for (int col = 0; col < pfb_pkg::GLYPH_COLS; col++) begin
            bits = font_cols[base + col];
            for (int row = 0; row < pfb_pkg::GLYPH_ROWS; row++) begin
               if (bits[row]) set_pixel(x + col, y + row, 1'b1);
            end
         end
      endfunction

      // Apply one accepted command word and queue the response it should give
      function void note_command(cmd_type c);
         rsp_type r;
         r = '0;
         case (c.opcode)
            pfb_pkg::OP_CLEAR: foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
            pfb_pkg::OP_PLOT:  set_pixel(c.pos_x, c.pos_y, c.pixel_on);
            pfb_pkg::OP_HLINE: begin
               for (int x = 0; x < pfb_pkg::SCREEN_WIDTH; x++) set_pixel(x, c.pos_y, 1'b1);
            end
            pfb_pkg::OP_CURSOR: begin
               cursor_col = 9'(c.pos_x);
               cursor_row = c.pos_y;
               line_full  = 1'b0;
            end
            pfb_pkg::OP_CHAR: begin
               if (!line_full) begin
                  draw_glyph(cursor_col, cursor_row, c.char_code);
                  cursor_col = cursor_col + 9'(pfb_pkg::CHAR_ADVANCE);
                  if (int'(cursor_col) > pfb_pkg::SCREEN_WIDTH - pfb_pkg::CHAR_ADVANCE) begin
                     line_full = 1'b1;
                  end
               end
            end
            pfb_pkg::OP_FONT: begin
               if (c.char_code >= pfb_pkg::FIRST_CODE && c.char_code <= pfb_pkg::LAST_CODE &&
                   c.font_column < pfb_pkg::GLYPH_COLS) begin
                  font_cols[(int'(c.char_code) - int'(pfb_pkg::FIRST_CODE))
                            * pfb_pkg::GLYPH_COLS + int'(c.font_column)] = c.font_bits;
               end
            end
            pfb_pkg::OP_READ: begin
               if (c.read_page < pfb_pkg::PAGE_COUNT && c.read_column < pfb_pkg::SCREEN_WIDTH)
                  r.read_data = frame_bytes[int'(c.read_page) * pfb_pkg::SCREEN_WIDTH
                                            + int'(c.read_column)];
            end
            default: ;
         endcase
         r.cursor_now   = cursor_col;
         r.text_stopped = line_full;
         expected_results.push_back(r);
      endfunction

      function void check_result(logic [23:0] word);
         rsp_type got, want;
         got = rsp_type'(word);
         if (expected_results.size() == 0) begin
            $error("response word %h with nothing expected", word);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
            errors++;
         end
         if (got.cursor_now !== want.cursor_now) begin
            $error("cursor_now: expected %0d, got %0d", want.cursor_now, got.cursor_now);
            errors++;
         end
         if (got.text_stopped !== want.text_stopped) begin
            $error("text_stopped: expected %0d, got %0d", want.text_stopped,
                   got.text_stopped);
            errors++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   frame_scoreboard sb = new();
   int idle_pct  = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   page_framebuffer_text_renderer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
      end
   end

   // Watchdog: count cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic cmd_type random_fields(logic [2:0] op);
      cmd_type c;
      c = cmd_type'(48'({$urandom, $urandom}));
      c.pad = 1'b0;
      c.opcode = op;
      return c;
   endfunction

   task automatic send_word(input cmd_type c);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      sb.note_command(c);
   endtask

   task automatic plot(int x, int y, bit on);
      cmd_type c;
      c = random_fields(pfb_pkg::OP_PLOT);
      c.pos_x = 8'(x);
      c.pos_y = 7'(y);
      c.pixel_on = on;
      send_word(c);
   endtask

   task automatic hline(int y);
      cmd_type c;
      c = random_fields(pfb_pkg::OP_HLINE);
      c.pos_y = 7'(y);
      send_word(c);
   endtask

   task automatic place_cursor(int x, int y);
      cmd_type c;
      c = random_fields(pfb_pkg::OP_CURSOR);
      c.pos_x = 8'(x);
      c.pos_y = 7'(y);
      send_word(c);
   endtask

   task automatic put_char(logic [7:0] code);
      cmd_type c;
      c = random_fields(pfb_pkg::OP_CHAR);
      c.char_code = code;
      send_word(c);
   endtask

   task automatic read_byte(int page, int col);
      cmd_type c;
      c = random_fields(pfb_pkg::OP_READ);
      c.read_page = 3'(page);
      c.read_column = 7'(col);
      send_word(c);
   endtask

   task automatic load_font(logic [7:0] code, int col);
      cmd_type c;
      c = random_fields(pfb_pkg::OP_FONT);
      c.char_code = code;
      c.font_column = 3'(col);
      send_word(c);
   endtask

   task automatic run_random(int n_items);
      int sent;
      int pick;
      int run_len;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 2) begin
            send_word(random_fields(pfb_pkg::OP_CLEAR));
            sent++;
         end else if (pick < 20) begin
            plot(($urandom_range(99) < 80) ? $urandom_range(pfb_pkg::SCREEN_WIDTH - 1)
                                           : $urandom_range(255),
                 ($urandom_range(99) < 80) ? $urandom_range(pfb_pkg::SCREEN_HEIGHT - 1)
                                           : $urandom_range(127),
                 $urandom_range(1));
            sent++;
         end else if (pick < 24) begin
            hline(($urandom_range(99) < 85) ? $urandom_range(pfb_pkg::SCREEN_HEIGHT - 1)
                                            : $urandom_range(127));
            sent++;
         end else if (pick < 50) begin
            // text run: mostly on screen, sometimes long enough to hit the right edge
            place_cursor(($urandom_range(99) < 85)
                            ? $urandom_range(pfb_pkg::SCREEN_WIDTH - 1)
                            : $urandom_range(255),
                         ($urandom_range(99) < 85)
                            ? $urandom_range(pfb_pkg::SCREEN_HEIGHT - 1)
                            : $urandom_range(127));
            run_len = $urandom_range(1, 24);
            repeat (run_len) begin
               put_char(($urandom_range(99) < 85)
                           ? 8'($urandom_range(pfb_pkg::FIRST_CODE, pfb_pkg::LAST_CODE))
                           : 8'($urandom_range(255)));
            end
            sent += run_len + 1;
         end else if (pick < 56) begin
            if ($urandom_range(99) < 70) begin
               load_font(8'($urandom_range(pfb_pkg::FIRST_CODE, pfb_pkg::LAST_CODE)),
                         $urandom_range(pfb_pkg::GLYPH_COLS - 1));
            end else begin
               send_word(random_fields(pfb_pkg::OP_FONT));
            end
            sent++;
         end else if (pick < 58) begin
            send_word(random_fields(OP_UNUSED));
            sent++;
         end else begin
            read_byte($urandom_range(7), $urandom_range(127));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // upload every glyph so no character ever draws from unwritten font
      idle_pct  = 31;
      stall_pct = 31;
      for (int g = 0; g < pfb_pkg::GLYPH_COUNT; g++) begin
         for (int col = 0; col < pfb_pkg::GLYPH_COLS; col++) begin
            load_font(8'(int'(pfb_pkg::FIRST_CODE) + g), col);
         end
      end

      idle_pct  = 0;
      stall_pct = 0;
      read_byte(0, 0);
      plot(0, 0, 1'b1);
      plot(pfb_pkg::SCREEN_WIDTH - 1, pfb_pkg::SCREEN_HEIGHT - 1, 1'b1);
      plot(pfb_pkg::SCREEN_WIDTH, 10, 1'b1);
      plot(5, pfb_pkg::SCREEN_HEIGHT, 1'b1);
      plot(255, 127, 1'b1);
      plot(0, 0, 1'b0);
      hline(pfb_pkg::SCREEN_HEIGHT - 1);
      hline(100);
      read_byte(pfb_pkg::PAGE_COUNT - 1, pfb_pkg::SCREEN_WIDTH - 1);
      place_cursor(0, 0);
      put_char("A");
      put_char(8'h10);
      put_char(8'hFF);
      read_byte(0, 1);
      // drawn clipped at the bottom edge, then the line is full and drops
      place_cursor(pfb_pkg::SCREEN_WIDTH - 8, pfb_pkg::SCREEN_HEIGHT - 4);
      put_char("W");
      put_char("X");
      place_cursor(255, 127);
      put_char("Z");
      load_font(8'h1F, 0);
      load_font(8'h7F, 4);
      load_font("B", 7);
      send_word(random_fields(OP_UNUSED));
      send_word(random_fields(pfb_pkg::OP_CLEAR));
      read_byte(pfb_pkg::PAGE_COUNT - 1, pfb_pkg::SCREEN_WIDTH - 1);

      run_random(180);
      idle_pct  = 68;
      stall_pct = 0;
      run_random(180);
      idle_pct  = 0;
      stall_pct = 68;
      run_random(180);
      idle_pct  = 31;
      stall_pct = 31;
      run_random(180);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
